FILE: design/gtd_pkg.sv
package gtd_pkg;

	localparam int MAX_BLOCK_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int DELAY_W = 48;
	localparam int COEF_W = 18;
	localparam int BLEN_W = 13;
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 17;
	localparam int LEVEL_W = 16;
	localparam int SUM_W = 32;
	localparam int MCNT_W = 16;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_COS = 2'd0;
	localparam logic [1:0] REG_SIN = 2'd1;
	localparam logic [1:0] REG_BLEN = 2'd2;

	localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd4096;

	localparam logic KIND_BLOCK = 1'b0;
	localparam logic KIND_SNAP = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;
	localparam logic [MCNT_W-1:0] MCNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic               kind;
		logic [DELAY_W-1:0] d1;
		logic [DELAY_W-1:0] d2;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: design/gtd_job_fifo.sv
module gtd_job_fifo
	import gtd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  job_t   wr_job,
	input  logic   rd_en,
	output job_t   rd_job,
	output qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/gtd_front.sv
module gtd_front
	import gtd_pkg::*;
#(
	parameter int LEN_W = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       req_type,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        window_weight,
	input  logic signed [COEF_W-1:0]   cos_coef,
	input  logic [LEN_W-1:0]           len_eff,
	input  qstat_t                     qstat,
	output logic                       job_push,
	output job_t                       job
);

	typedef enum logic {F_IDLE, F_ADD} fstate_t;

	fstate_t state_q;
	logic [DELAY_W-1:0] d1_q, d2_q;
	logic [LEN_W-1:0] count_q;

	logic signed [42:0] pp_lo_s1;
	logic signed [41:0] pp_hi_s1;
	logic signed [33:0] x_s1;

	logic accept;
	logic signed [65:0] prod;
	logic [DELAY_W-1:0] y;
	logic blk_end;

	assign full = (state_q != F_IDLE) || qstat.full;
	assign accept = push && !full;

	always_comb begin
		prod = (66'(pp_hi_s1) <<< 24) + 66'(pp_lo_s1);
		y = prod[63:16] - d2_q + DELAY_W'(x_s1);
		blk_end = ((LEN_W + 1)'(count_q) + 1'b1) >= (LEN_W + 1)'(len_eff);
	end

	always_comb begin
		job_push = 1'b0;
		job = '0;
		if (accept && req_type) begin
			job_push = 1'b1;
			job.kind = KIND_SNAP;
		end else if (state_q == F_ADD && blk_end) begin
			job_push = 1'b1;
			job.kind = KIND_BLOCK;
			job.d1 = y;
			job.d2 = d1_q;
		end
	end

	// partial products of the recurrence, split on the delay word
	always_ff @(posedge clk) begin
		if (accept && !req_type) begin
			pp_lo_s1 <= cos_coef * $signed({1'b0, d1_q[23:0]});
			pp_hi_s1 <= cos_coef * $signed(d1_q[47:24]);
			x_s1 <= sample * $signed({1'b0, window_weight});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			d1_q <= '0;
			d2_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && !req_type) begin
						state_q <= F_ADD;
					end
				end
				F_ADD: begin
					if (blk_end) begin
						d1_q <= '0;
						d2_q <= '0;
						count_q <= '0;
					end else begin
						d2_q <= d1_q;
						d1_q <= y;
						count_q <= count_q + 1'b1;
					end
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: design/gtd_back.sv
module gtd_back
	import gtd_pkg::*;
#(
	parameter int LEN_W = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  job_t                     job,
	input  qstat_t                   qstat,
	output logic                     job_pop,
	input  logic signed [COEF_W-1:0] cos_coef,
	input  logic signed [COEF_W-1:0] sin_coef,
	input  logic [LEN_W-1:0]         len_eff,
	output logic                     empty,
	input  logic                     pop,
	output logic                     result_kind,
	output logic [LEVEL_W-1:0]       level
);

	localparam int DIV_W = (LEN_W > MCNT_W) ? LEN_W : MCNT_W;
	localparam int ACC_W = 92;
	localparam logic [5:0] SQRT_LAST = 6'd45;
	localparam logic [5:0] DIV_LAST = 6'd31;

	// multiply schedule: two products against the delay, then two squares
	localparam logic [3:0] ST_P1_LO = 4'd0;
	localparam logic [3:0] ST_P1_HI = 4'd1;
	localparam logic [3:0] ST_P2_LO = 4'd2;
	localparam logic [3:0] ST_P2_HI = 4'd3;
	localparam logic [3:0] ST_R_LL = 4'd4;
	localparam logic [3:0] ST_R_HL = 4'd5;
	localparam logic [3:0] ST_R_HH = 4'd6;
	localparam logic [3:0] ST_I_LL = 4'd7;
	localparam logic [3:0] ST_I_HL = 4'd8;
	localparam logic [3:0] ST_I_HH = 4'd9;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL, B_ACC, B_RE, B_IM, B_ABS, B_SQRT, B_DIV, B_DONE
	} bstate_t;

	bstate_t state_q;
	logic kind_q;
	logic [DELAY_W-1:0] d1m_q;
	logic d1neg_q;
	logic signed [DELAY_W-1:0] d2_q;
	logic [COEF_W-1:0] cm_q, sm_q;
	logic cneg_q, sneg_q;
	logic [3:0] step_q;
	logic [47:0] prod_q;
	logic [ACC_W-1:0] acc_q;
	logic signed [49:0] re_q, im_q;
	logic [44:0] ar_q, ai_q;
	logic [47:0] rem_q;
	logic [45:0] root_q;
	logic [5:0] iter_q;
	logic [SUM_W-1:0] dvd_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W-1:0] drem_q;
	logic [LEVEL_W-1:0] lev_q;
	logic [SUM_W-1:0] sum_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [LEVEL_W-1:0] avg_q;
	logic out_valid_q, out_kind_q;
	logic [LEVEL_W-1:0] out_level_q;

	logic [23:0] opa, opb;
	logic [5:0] sh;
	logic signed [66:0] sp1, sp2;
	logic signed [49:0] re_n, im_n;
	logic [49:0] are, aim;
	logic [49:0] rem_n, trial;
	logic rbit;
	logic [45:0] root_n;
	logic [DIV_W:0] drem_n;
	logic qbit;
	logic [SUM_W-1:0] quo;
	logic load_out;

	assign empty = !out_valid_q;
	assign result_kind = out_kind_q;
	assign level = out_level_q;
	assign job_pop = (state_q == B_IDLE) && !qstat.empty;
	assign load_out = (state_q == B_DONE) && (!out_valid_q || pop);

	always_comb begin
		opa = '0;
		opb = '0;
		sh = '0;
		case (step_q)
			ST_P1_LO: begin opa = 24'(cm_q); opb = d1m_q[23:0]; sh = 6'd0; end
			ST_P1_HI: begin opa = 24'(cm_q); opb = d1m_q[47:24]; sh = 6'd24; end
			ST_P2_LO: begin opa = 24'(sm_q); opb = d1m_q[23:0]; sh = 6'd0; end
			ST_P2_HI: begin opa = 24'(sm_q); opb = d1m_q[47:24]; sh = 6'd24; end
			ST_R_LL: begin opa = ar_q[23:0]; opb = ar_q[23:0]; sh = 6'd0; end
			ST_R_HL: begin opa = 24'(ar_q[44:24]); opb = ar_q[23:0]; sh = 6'd25; end
			ST_R_HH: begin opa = 24'(ar_q[44:24]); opb = 24'(ar_q[44:24]); sh = 6'd48; end
			ST_I_LL: begin opa = ai_q[23:0]; opb = ai_q[23:0]; sh = 6'd0; end
			ST_I_HL: begin opa = 24'(ai_q[44:24]); opb = ai_q[23:0]; sh = 6'd25; end
			ST_I_HH: begin opa = 24'(ai_q[44:24]); opb = 24'(ai_q[44:24]); sh = 6'd48; end
			default: begin opa = '0; opb = '0; sh = '0; end
		endcase
	end

	always_comb begin
		// floor division of a sign-magnitude product
		sp1 = (cneg_q ^ d1neg_q) ? -$signed({1'b0, acc_q[65:0]}) : $signed({1'b0, acc_q[65:0]});
		sp2 = (sneg_q ^ d1neg_q) ? -$signed({1'b0, acc_q[65:0]}) : $signed({1'b0, acc_q[65:0]});
		re_n = 50'(sp1 >>> 17) - 50'(d2_q);
		im_n = 50'(sp2 >>> 16);
		are = re_q[49] ? 50'(-re_q) : 50'(re_q);
		aim = im_q[49] ? 50'(-im_q) : 50'(im_q);

		rem_n = {rem_q, acc_q[ACC_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		rbit = (rem_n >= trial);
		root_n = {root_q[44:0], rbit};

		drem_n = {drem_q, dvd_q[SUM_W-1]};
		qbit = (drem_n >= {1'b0, dvs_q});
		quo = {dvd_q[SUM_W-2:0], qbit};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					kind_q <= job.kind;
					d1m_q <= job.d1[DELAY_W-1] ? -job.d1 : job.d1;
					d1neg_q <= job.d1[DELAY_W-1];
					d2_q <= job.d2;
					cm_q <= cos_coef[COEF_W-1] ? -cos_coef : cos_coef;
					cneg_q <= cos_coef[COEF_W-1];
					sm_q <= sin_coef[COEF_W-1] ? -sin_coef : sin_coef;
					sneg_q <= sin_coef[COEF_W-1];
					acc_q <= '0;
					step_q <= ST_P1_LO;
					lev_q <= avg_q;
					dvd_q <= sum_q;
					dvs_q <= DIV_W'(cnt_q);
					drem_q <= '0;
					iter_q <= '0;
				end
			end
			B_MUL: prod_q <= opa * opb;
			B_ACC: begin
				acc_q <= acc_q + (ACC_W'(prod_q) << sh);
				step_q <= step_q + 1'b1;
				rem_q <= '0;
				root_q <= '0;
				iter_q <= '0;
			end
			B_RE: begin
				re_q <= re_n;
				acc_q <= '0;
			end
			B_IM: im_q <= im_n;
			B_ABS: begin
				ar_q <= are[44:0];
				ai_q <= aim[44:0];
				acc_q <= '0;
				lev_q <= LEVEL_MAX;
			end
			B_SQRT: begin
				rem_q <= rbit ? 48'(rem_n - trial) : rem_n[47:0];
				root_q <= root_n;
				acc_q <= acc_q << 2;
				iter_q <= iter_q + 1'b1;
				if (iter_q == SQRT_LAST) begin
					dvd_q <= SUM_W'(root_n[45:16]);
					dvs_q <= DIV_W'(len_eff);
					drem_q <= '0;
					iter_q <= '0;
				end
			end
			B_DIV: begin
				drem_q <= qbit ? DIV_W'(drem_n - {1'b0, dvs_q}) : drem_n[DIV_W-1:0];
				dvd_q <= quo;
				iter_q <= iter_q + 1'b1;
				if (iter_q == DIV_LAST) begin
					if (kind_q == KIND_BLOCK && quo[SUM_W-1:LEVEL_W] != '0) begin
						lev_q <= LEVEL_MAX;
					end else begin
						lev_q <= quo[LEVEL_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sum_q <= '0;
			cnt_q <= '0;
			avg_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= KIND_BLOCK;
			out_level_q <= '0;
		end else begin
			if (out_valid_q && pop && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						if (job.kind == KIND_BLOCK) begin
							state_q <= B_MUL;
						end else if (cnt_q == '0) begin
							state_q <= B_DONE;
						end else begin
							state_q <= B_DIV;
						end
					end
				end
				B_MUL: state_q <= B_ACC;
				B_ACC: begin
					case (step_q)
						ST_P1_HI: state_q <= B_RE;
						ST_P2_HI: state_q <= B_IM;
						ST_I_HH: state_q <= B_SQRT;
						default: state_q <= B_MUL;
					endcase
				end
				B_RE: state_q <= B_MUL;
				B_IM: state_q <= B_ABS;
				B_ABS: begin
					if (are[49:45] != '0 || aim[49:45] != '0) begin
						state_q <= B_DONE;
					end else begin
						state_q <= B_MUL;
					end
				end
				B_SQRT: begin
					if (iter_q == SQRT_LAST) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (iter_q == DIV_LAST) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_kind_q <= kind_q;
						out_level_q <= lev_q;
						if (kind_q == KIND_SNAP) begin
							avg_q <= lev_q;
							sum_q <= '0;
							cnt_q <= '0;
						end else if (cnt_q != MCNT_MAX) begin
							sum_q <= sum_q + SUM_W'(lev_q);
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: design/goertzel_tone_detector_core.sv
// Single-bin Goertzel tone detector. Audio samples (req_type 0) are windowed and
// run through the Goertzel recurrence in the front end, which forms the two
// partial products and then does the add and delay update, taking no new sample
// until that update is done. When block_length samples are in (0 or above
// MAX_BLOCK means MAX_BLOCK), the final delays go into a job queue of QUEUE_DEPTH
// entries; the back end forms the magnitude with one shared 24x24 multiplier
// (10 products), a 46-step bit-serial square root and a 32-step divider, and also
// keeps the running average. A snapshot request (req_type 1) runs the divider in
// the back end when new magnitudes arrived. Results leave through one output
// register read with pop/empty.
// Registers: 0x0 cosine_coef, 0x4 sine_coef, 0x8 block_length.
module goertzel_tone_detector_core
	import gtd_pkg::*;
#(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       req_type,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        window_weight,
	output logic                       empty,
	input  logic                       pop,
	output logic                       result_kind,
	output logic [LEVEL_W-1:0]         level,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready
);

	localparam int LEN_W = $clog2(MAX_BLOCK + 1);

	logic signed [COEF_W-1:0] cos_q, sin_q;
	logic [BLEN_W-1:0] blen_q;
	logic [LEN_W-1:0] len_eff;
	logic cfg_wr;

	logic job_push, job_pop;
	job_t job_in, job_out;
	qstat_t qstat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		if (blen_q == '0 || 32'(blen_q) > 32'(MAX_BLOCK)) begin
			len_eff = LEN_W'(MAX_BLOCK);
		end else begin
			len_eff = LEN_W'(blen_q);
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COS: prdata = DATA_W'(cos_q[COEF_W-1:0]);
			REG_SIN: prdata = DATA_W'(sin_q[COEF_W-1:0]);
			REG_BLEN: prdata = DATA_W'(blen_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= '0;
			sin_q <= '0;
			blen_q <= BLEN_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COS: cos_q <= pwdata[COEF_W-1:0];
				REG_SIN: sin_q <= pwdata[COEF_W-1:0];
				REG_BLEN: blen_q <= pwdata[BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	gtd_front #(.LEN_W(LEN_W)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.sample       (sample),
		.window_weight(window_weight),
		.cos_coef     (cos_q),
		.len_eff      (len_eff),
		.qstat        (qstat),
		.job_push     (job_push),
		.job          (job_in)
	);

	gtd_job_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (job_push),
		.wr_job(job_in),
		.rd_en (job_pop),
		.rd_job(job_out),
		.stat  (qstat)
	);

	gtd_back #(.LEN_W(LEN_W)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_out),
		.qstat      (qstat),
		.job_pop    (job_pop),
		.cos_coef   (cos_q),
		.sin_coef   (sin_q),
		.len_eff    (len_eff),
		.empty      (empty),
		.pop        (pop),
		.result_kind(result_kind),
		.level      (level)
	);

endmodule

FILE: design/gtd_checker.sv
module gtd_checker
	import gtd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input logic                result_kind,
	input logic [LEVEL_W-1:0]  level,
	input logic                psel,
	input logic [ADDR_W-1:0]   paddr,
	input logic [DATA_W-1:0]   prdata,
	input logic                pready
);

	// a waiting result holds until it is popped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(level) && $stable(result_kind))
		else $error("result changed before pop");

	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("result shown during reset");

	a_ready: assert property (@(posedge clk) pready)
		else $error("pready dropped");

	// coefficient readback is 18 bits, zero-filled above
	a_prdata_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && (paddr[3:2] == REG_COS || paddr[3:2] == REG_SIN) |-> prdata[31:18] == '0)
		else $error("coefficient readback has stray upper bits");

endmodule

bind goertzel_tone_detector_core gtd_checker u_gtd_checker (.*);

FILE: tb/goertzel_tone_detector_core_tb.sv
`timescale 1ns / 1ps

module goertzel_tone_detector_core_tb;
	import gtd_pkg::*;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_SNAPSHOT = 1'b1;
	localparam int DRAIN_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic               kind;
		logic [LEVEL_W-1:0] lvl;
	} level_exp_t;

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] sample;
	logic [WEIGHT_W-1:0]        window_weight;
	logic                       empty;
	logic                       pop;
	logic                       result_kind;
	logic [LEVEL_W-1:0]         level;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;

	// predictor state
	logic [COEF_W-1:0]          cos_r;
	logic [COEF_W-1:0]          sin_r;
	logic [BLEN_W-1:0]          blen_r;
	logic signed [DELAY_W-1:0]  dly1;
	logic signed [DELAY_W-1:0]  dly2;
	int unsigned                taken;
	logic [SUM_W-1:0]           mag_sum;
	logic [MCNT_W-1:0]          mag_cnt;
	logic [LEVEL_W-1:0]         last_avg;

	level_exp_t levels_due[$];
	int errors;
	int n_blocks;
	int n_snaps;
	int n_samples;
	int idle_cycles;
	bit timed_out;
	bit calm;

	goertzel_tone_detector_core i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	function automatic logic [LEVEL_W-1:0] block_magnitude(int unsigned len);
		logic signed [79:0] pc, ps, re, im;
		logic [79:0] ar, ai;
		logic [127:0] sq;
		logic [63:0] root, c, q;
		pc = $signed(cos_r) * dly1;
		ps = $signed(sin_r) * dly1;
		re = (pc >>> 17) - dly2;
		im = ps >>> 16;
		ar = re < 0 ? -re : re;
		ai = im < 0 ? -im : im;
		if (ar >= (80'd1 << 45) || ai >= (80'd1 << 45))
			return LEVEL_MAX;
		sq = ar * ar + ai * ai;
		root = '0;
		for (int b = 45; b >= 0; b--) begin
			c = root | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= sq)
				root = c;
		end
		q = (root >> 16) / len;
		return q > 65535 ? LEVEL_MAX : q[LEVEL_W-1:0];
	endfunction

	// advance the model by one accepted transaction
	task automatic predict(logic rt, logic signed [SAMPLE_W-1:0] s, logic [WEIGHT_W-1:0] w);
		logic signed [65:0] pr;
		logic signed [DELAY_W-1:0] x;
		int unsigned len;
		level_exp_t e;
		if (rt == REQ_SNAPSHOT) begin
			if (mag_cnt > 0) begin
				last_avg = LEVEL_W'(mag_sum / mag_cnt);
				mag_sum = '0;
				mag_cnt = '0;
			end
			e.kind = KIND_SNAP;
			e.lvl = last_avg;
			levels_due.push_back(e);
			n_snaps++;
			return;
		end
		n_samples++;
		pr = $signed(cos_r) * dly1;
		x = s * $signed({1'b0, w});
		x = pr[63:16] - dly2 + x;
		dly2 = dly1;
		dly1 = x;
		taken++;
		len = (blen_r == 0 || blen_r > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : blen_r;
		if (taken < len)
			return;
		e.kind = KIND_BLOCK;
		e.lvl = block_magnitude(len);
		if (mag_cnt < MCNT_MAX) begin
			mag_sum = mag_sum + e.lvl;
			mag_cnt++;
		end
		dly1 = '0;
		dly2 = '0;
		taken = 0;
		levels_due.push_back(e);
		n_blocks++;
	endtask

	task automatic send(logic rt, logic signed [SAMPLE_W-1:0] s, logic [WEIGHT_W-1:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= rt;
		sample <= s;
		window_weight <= w;
		do @(posedge clk); while (full);
		predict(rt, s, w);
	endtask

	task automatic send_rand_sample();
		logic [WEIGHT_W-1:0] w;
		case ($urandom_range(5))
			0: w = '0;
			1: w = 17'd65536;
			2: w = 17'h1FFFF;
			default: w = WEIGHT_W'($urandom);
		endcase
		send(REQ_SAMPLE, SAMPLE_W'($urandom), w);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (levels_due.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COS: cos_r = v[COEF_W-1:0];
			REG_SIN: sin_r = v[COEF_W-1:0];
			default: blen_r = v[BLEN_W-1:0];
		endcase
	endtask

	task automatic set_bin(int c, int s, int len);
		settle();
		reg_write(REG_COS, c);
		reg_write(REG_SIN, s);
		reg_write(REG_BLEN, len);
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (levels_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result kind=%0d level=%0d", result_kind, level);
				end else begin
					level_exp_t e;
					e = levels_due.pop_front();
					if (e.kind !== result_kind || e.lvl !== level) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected kind=%0d level=%0d, got kind=%0d level=%0d",
								e.kind, e.lvl, result_kind, level);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(99) < 25) begin
				stall = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(80, 20);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_empty_snapshot();
		send(REQ_SNAPSHOT, '0, '0);
		send(REQ_SNAPSHOT, 16'h7FFF, 17'h1FFFF);
	endtask

	task automatic test_field_extremes();
		set_bin(-131072, 65536, 4);
		send(REQ_SAMPLE, -16'sd32768, 17'h1FFFF);
		send(REQ_SAMPLE, 16'sd32767, 17'd65536);
		send(REQ_SAMPLE, 16'sd0, 17'd0);
		send(REQ_SAMPLE, -16'sd1, 17'd1);
		send(REQ_SNAPSHOT, 16'h5555, 17'h0AAAA);
		set_bin(131071, -65536, 1);
		send(REQ_SAMPLE, 16'sd32767, 17'h1FFFF);
		send(REQ_SAMPLE, -16'sd32768, 17'd65536);
		send(REQ_SNAPSHOT, '0, '0);
		send(REQ_SNAPSHOT, '0, '0);
	endtask

	// resonant DC input drives the delays past the saturation bound and wraps them
	task automatic test_huge_magnitude();
		set_bin(131071, 65536, 256);
		repeat (256) send(REQ_SAMPLE, 16'sd32767, 17'h1FFFF);
		set_bin(131071, 0, 4096);
		repeat (60) send(REQ_SAMPLE, -16'sd32768, 17'h1FFFF);
		send(REQ_SNAPSHOT, '0, '0);
	endtask

	// length lowered mid-block; 0 and 8191 act as the maximum, so no block ends early
	task automatic test_length_changes();
		set_bin(60000, 30000, 8);
		repeat (6) send_rand_sample();
		settle();
		reg_write(REG_BLEN, 3);
		send_rand_sample();
		set_bin(90000, 40000, 0);
		repeat (20) send_rand_sample();
		settle();
		reg_write(REG_BLEN, 8191);
		repeat (20) send_rand_sample();
		settle();
		reg_write(REG_BLEN, 30);
		send_rand_sample();
		send(REQ_SNAPSHOT, '0, '0);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 12; ph++) begin
			set_bin($signed($urandom_range(262143)) - 131072,
				$signed($urandom_range(131072)) - 65536,
				(ph % 5 == 4) ? $urandom_range(40, 17) : $urandom_range(12, 1));
			calm = (ph % 4 == 3);
			repeat (56) begin
				if ($urandom_range(99) < 10)
					send(REQ_SNAPSHOT, SAMPLE_W'($urandom), WEIGHT_W'($urandom));
				else
					send_rand_sample();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		req_type = REQ_SAMPLE;
		sample = '0;
		window_weight = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cos_r = '0;
		sin_r = '0;
		blen_r = BLEN_RESET;
		dly1 = '0;
		dly2 = '0;
		taken = 0;
		mag_sum = '0;
		mag_cnt = '0;
		last_avg = '0;
		errors = 0;
		n_blocks = 0;
		n_snaps = 0;
		n_samples = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_snapshot();
		test_field_extremes();
		test_huge_magnitude();
		test_length_changes();
		test_random();
		settle();
		$display("covered %0d samples, %0d block magnitudes, %0d snapshot averages",
			n_samples, n_blocks, n_snaps);
		$display("block lengths 1..40 and 256, out-of-range lengths, saturation, coefficient extremes");
		if (errors == 0 && levels_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, levels_due.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
